>>> rtl/mdsd_pkg.sv
// shared constants, types and helpers of the minimum distance symbol demapper
`default_nettype none

package mdsd_pkg;

  // fixed field widths of the item and configuration words
  localparam int PointIdxW = 6;
  localparam int BpsW      = 3;

  // defaults of the top level parameters
  localparam int MaxPointsDefault   = 64;
  localparam int SampleWidthDefault = 16;

  // constellation size register
  localparam logic [BpsW-1:0] BpsReset = 3'd2;
  localparam logic [BpsW-1:0] BpsMin   = 3'd1;
  localparam logic [BpsW-1:0] BpsMax   = 3'd6;

  // register stages between input and output
  localparam int NumStages = 6;

  typedef enum logic {
    ActLoad  = 1'b0,
    ActDemap = 1'b1
  } action_e;

  // out of range sizes fall back to the nearest legal one
  function automatic logic [BpsW-1:0] clamp_bps(input logic [BpsW-1:0] bps);
    logic [BpsW-1:0] res;
    res = bps;
    if (bps < BpsMin) begin
      res = BpsMin;
    end else if (bps > BpsMax) begin
      res = BpsMax;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

>>> rtl/mdsd_point_table.sv
// constellation point table, one register pair per search lane
`default_nettype none

module mdsd_point_table #(
  parameter int NumLanes    = 64,
  parameter int SampleWidth = 16
) (
  input  wire logic                                clk_i,
  input  wire logic                                we_i,
  input  wire logic [mdsd_pkg::PointIdxW-1:0]      wr_idx_i,
  input  wire logic signed [SampleWidth-1:0]       wr_re_i,
  input  wire logic signed [SampleWidth-1:0]       wr_im_i,
  output logic signed [SampleWidth-1:0]            pt_re_o [NumLanes],
  output logic signed [SampleWidth-1:0]            pt_im_o [NumLanes]
);

  logic signed [SampleWidth-1:0] re_q [NumLanes];
  logic signed [SampleWidth-1:0] im_q [NumLanes];

  // entries hold garbage until loaded
  always_ff @(posedge clk_i) begin
    for (int n = 0; n < NumLanes; n++) begin
      if (we_i && (wr_idx_i == mdsd_pkg::PointIdxW'(n))) begin
        re_q[n] <= wr_re_i;
        im_q[n] <= wr_im_i;
      end
    end
  end

  assign pt_re_o = re_q;
  assign pt_im_o = im_q;

endmodule

`default_nettype wire

>>> rtl/mdsd_dist.sv
// per lane squared distance, two register stages
`default_nettype none

module mdsd_dist #(
  parameter int NumLanes    = 64,
  parameter int SampleWidth = 16,
  localparam int DistW      = 2 * SampleWidth + 2
) (
  input  wire logic                              clk_i,
  input  wire logic [1:0]                        stage_en_i,
  input  wire logic signed [SampleWidth-1:0]     smp_re_i,
  input  wire logic signed [SampleWidth-1:0]     smp_im_i,
  input  wire logic [mdsd_pkg::BpsW-1:0]         bps_i,
  input  wire logic signed [SampleWidth-1:0]     pt_re_i [NumLanes],
  input  wire logic signed [SampleWidth-1:0]     pt_im_i [NumLanes],
  output logic                                   lane_en_o [NumLanes],
  output logic [DistW-1:0]                       dist_o [NumLanes],
  output logic signed [SampleWidth-1:0]          re_o [NumLanes],
  output logic signed [SampleWidth-1:0]          im_o [NumLanes]
);

  localparam int DiffW = SampleWidth + 1;
  localparam int SqW   = 2 * SampleWidth + 1;

  logic signed [DiffW-1:0]         diff_re [NumLanes];
  logic signed [DiffW-1:0]         diff_im [NumLanes];
  logic signed [2*DiffW-1:0]       prod_re [NumLanes];
  logic signed [2*DiffW-1:0]       prod_im [NumLanes];
  logic                            lane_en_d [NumLanes];

  logic [SqW-1:0]                  sq_re_q [NumLanes];
  logic [SqW-1:0]                  sq_im_q [NumLanes];
  logic signed [SampleWidth-1:0]   re1_q [NumLanes];
  logic signed [SampleWidth-1:0]   im1_q [NumLanes];
  logic                            en1_q [NumLanes];

  logic [DistW-1:0]                dist_q [NumLanes];
  logic signed [SampleWidth-1:0]   re2_q [NumLanes];
  logic signed [SampleWidth-1:0]   im2_q [NumLanes];
  logic                            en2_q [NumLanes];

  always_comb begin
    for (int n = 0; n < NumLanes; n++) begin
      diff_re[n]   = DiffW'(smp_re_i) - DiffW'(pt_re_i[n]);
      diff_im[n]   = DiffW'(smp_im_i) - DiffW'(pt_im_i[n]);
      prod_re[n]   = diff_re[n] * diff_re[n];
      prod_im[n]   = diff_im[n] * diff_im[n];
      // lane takes part when its index is below two to the bps
      lane_en_d[n] = ((32'(n) >> bps_i) == 32'd0);
    end
  end

  // stage: squares
  always_ff @(posedge clk_i) begin
    if (stage_en_i[0]) begin
      for (int n = 0; n < NumLanes; n++) begin
        sq_re_q[n] <= prod_re[n][SqW-1:0];
        sq_im_q[n] <= prod_im[n][SqW-1:0];
        re1_q[n]   <= pt_re_i[n];
        im1_q[n]   <= pt_im_i[n];
        en1_q[n]   <= lane_en_d[n];
      end
    end
  end

  // stage: sum of squares
  always_ff @(posedge clk_i) begin
    if (stage_en_i[1]) begin
      for (int n = 0; n < NumLanes; n++) begin
        dist_q[n] <= DistW'(sq_re_q[n]) + DistW'(sq_im_q[n]);
        re2_q[n]  <= re1_q[n];
        im2_q[n]  <= im1_q[n];
        en2_q[n]  <= en1_q[n];
      end
    end
  end

  assign lane_en_o = en2_q;
  assign dist_o    = dist_q;
  assign re_o      = re2_q;
  assign im_o      = im2_q;

endmodule

`default_nettype wire

>>> rtl/mdsd_min_tree.sv
// registered compare tree, three stages, lowest index wins a tie
`default_nettype none

module mdsd_min_tree #(
  parameter int NumLanes    = 64,
  parameter int SampleWidth = 16,
  localparam int DistW      = 2 * SampleWidth + 2,
  localparam int LevW       = $clog2(NumLanes)
) (
  input  wire logic                              clk_i,
  input  wire logic [2:0]                        stage_en_i,
  input  wire logic                              lane_en_i [NumLanes],
  input  wire logic [DistW-1:0]                  dist_i [NumLanes],
  input  wire logic signed [SampleWidth-1:0]     re_i [NumLanes],
  input  wire logic signed [SampleWidth-1:0]     im_i [NumLanes],
  output logic [LevW-1:0]                        best_idx_o,
  output logic signed [SampleWidth-1:0]          best_re_o,
  output logic signed [SampleWidth-1:0]          best_im_o
);

  localparam int Leaves = 1 << LevW;
  // last tree level finished by each register stage
  localparam int Bnd [4] = '{0, (LevW + 2) / 3, (2 * LevW + 2) / 3, LevW};

  typedef struct packed {
    logic                          en;
    logic [DistW-1:0]              sqd;
    logic [LevW-1:0]               idx;
    logic signed [SampleWidth-1:0] re;
    logic signed [SampleWidth-1:0] im;
  } node_t;

  node_t leaf  [Leaves];
  node_t cur   [Leaves];
  node_t nxt   [Leaves];
  node_t stg_d [3][Leaves];
  node_t stg_q [3][Leaves];

  // right child wins only on a strictly smaller distance or when the left child is disabled
  function automatic node_t pick(input node_t a, input node_t b);
    node_t res;
    res = a;
    if (b.en && (!a.en || (b.sqd < a.sqd))) begin
      res = b;
    end
    return res;
  endfunction

  always_comb begin
    for (int j = 0; j < Leaves; j++) begin
      leaf[j] = '0;
      if (j < NumLanes) begin
        leaf[j].en  = lane_en_i[j];
        leaf[j].sqd = dist_i[j];
        leaf[j].idx = LevW'(j);
        leaf[j].re  = re_i[j];
        leaf[j].im  = im_i[j];
      end
    end
  end

  always_comb begin
    cur = leaf;
    nxt = '{default: '0};
    for (int k = 0; k < 3; k++) begin
      if (k == 0) begin
        cur = leaf;
      end else begin
        cur = stg_q[k-1];
      end
      for (int l = Bnd[k]; l < Bnd[k+1]; l++) begin
        nxt = '{default: '0};
        for (int j = 0; j < Leaves / 2; j++) begin
          if (j < (Leaves >> (l + 1))) begin
            nxt[j] = pick(cur[2*j], cur[2*j+1]);
          end
        end
        cur = nxt;
      end
      stg_d[k] = cur;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      if (stage_en_i[k]) begin
        stg_q[k] <= stg_d[k];
      end
    end
  end

  assign best_idx_o = stg_q[2][0].idx;
  assign best_re_o  = stg_q[2][0].re;
  assign best_im_o  = stg_q[2][0].im;

endmodule

`default_nettype wire

>>> rtl/min_distance_symbol_demapper_core.sv
// top level of the hard decision minimum distance symbol demapper
// usage:
//   input channel (in_valid_i / in_stall_o) carries one word per cycle unless
//   stalled: a load word writes one constellation point at point_index_i, a
//   demap word carries an equalized Q3.12 sample; a load gives no output word
//   output channel (out_valid_o / out_stall_i) gives, per demap word, the index
//   of the nearest of the first 2^bits_per_symbol points (size clamped to
//   1..6), that point, and the end of symbol flag. ties go to the lowest index
//   config channel (cfg_valid_i / cfg_ready_o) writes bits_per_symbol, always
//   ready; write it only while no demap word is in flight
// timing:
//   six register stages: input, squares, sums, then three compare tree stages
//   of about two levels each. throughput one word per cycle while the output
//   is not stalled. every lane has its own subtract, squarers and adder, so
//   all points are searched in one pass
// reset:
//   clears the stage valid bits and sets bits_per_symbol to 2. the point table
//   is not cleared; load every point that will be searched before demapping
// stall:
//   a stalled output holds its word; bubbles inside the pipe are squeezed out,
//   and in_stall_o rises only once every stage is full
`default_nettype none

module min_distance_symbol_demapper_core #(
  parameter int MaxPoints   = mdsd_pkg::MaxPointsDefault,
  parameter int SampleWidth = mdsd_pkg::SampleWidthDefault
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // input words
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire logic                                action_i,
  input  wire logic [mdsd_pkg::PointIdxW-1:0]      point_index_i,
  input  wire logic signed [SampleWidth-1:0]       value_real_i,
  input  wire logic signed [SampleWidth-1:0]       value_imag_i,
  input  wire logic                                last_subcarrier_i,
  // output words
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic [mdsd_pkg::PointIdxW-1:0]           symbol_index_o,
  output logic signed [SampleWidth-1:0]            nearest_real_o,
  output logic signed [SampleWidth-1:0]            nearest_imag_o,
  output logic                                     end_of_symbol_o,
  // configuration
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [mdsd_pkg::BpsW-1:0]           cfg_data_i
);

  // the index field cannot address more than 64 points
  localparam int IdxSpan  = 1 << mdsd_pkg::PointIdxW;
  localparam int NumLanes = (MaxPoints < IdxSpan) ? MaxPoints : IdxSpan;
  localparam int DistW    = 2 * SampleWidth + 2;
  localparam int LevW     = $clog2(NumLanes);
  localparam int NStg     = mdsd_pkg::NumStages;

  // configuration register
  logic [mdsd_pkg::BpsW-1:0] bps_q;

  // stage control
  logic [NStg-1:0] vld_q;
  logic [NStg-1:0] vld_d;
  logic [NStg-1:0] last_q;
  logic [NStg-1:0] stage_en;
  logic            in_accept;
  logic            is_demap;
  logic            tbl_we;

  // input stage payload
  logic signed [SampleWidth-1:0] s1_re_q;
  logic signed [SampleWidth-1:0] s1_im_q;
  logic [mdsd_pkg::BpsW-1:0]     s1_bps_q;

  // table and lane signals
  logic signed [SampleWidth-1:0] pt_re [NumLanes];
  logic signed [SampleWidth-1:0] pt_im [NumLanes];
  logic                          lane_en [NumLanes];
  logic [DistW-1:0]              lane_dist [NumLanes];
  logic signed [SampleWidth-1:0] lane_re [NumLanes];
  logic signed [SampleWidth-1:0] lane_im [NumLanes];
  logic [LevW-1:0]               best_idx;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bps_q <= mdsd_pkg::BpsReset;
    end else if (cfg_valid_i) begin
      bps_q <= cfg_data_i;
    end
  end

  // a stage moves when it is empty or the stage after it moves
  always_comb begin
    stage_en[NStg-1] = !vld_q[NStg-1] || !out_stall_i;
    for (int k = NStg - 2; k >= 0; k--) begin
      stage_en[k] = !vld_q[k] || stage_en[k+1];
    end
  end

  assign in_stall_o = !stage_en[0];
  assign in_accept  = in_valid_i && !in_stall_o;
  assign is_demap   = (action_i == mdsd_pkg::ActDemap);
  // load words write the table at accept, so older demap words never see them
  assign tbl_we     = in_accept && (action_i == mdsd_pkg::ActLoad);

  always_comb begin
    vld_d = vld_q;
    for (int k = 0; k < NStg; k++) begin
      if (stage_en[k]) begin
        if (k == 0) begin
          vld_d[k] = in_accept && is_demap;
        end else begin
          vld_d[k] = vld_q[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // end of symbol flag rides along with the valid bits
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NStg; k++) begin
      if (stage_en[k]) begin
        if (k == 0) begin
          last_q[k] <= last_subcarrier_i;
        end else begin
          last_q[k] <= last_q[k-1];
        end
      end
    end
  end

  // input stage
  always_ff @(posedge clk_i) begin
    if (stage_en[0]) begin
      s1_re_q  <= value_real_i;
      s1_im_q  <= value_imag_i;
      s1_bps_q <= mdsd_pkg::clamp_bps(bps_q);
    end
  end

  mdsd_point_table #(
    .NumLanes    (NumLanes),
    .SampleWidth (SampleWidth)
  ) u_table (
    .clk_i    (clk_i),
    .we_i     (tbl_we),
    .wr_idx_i (point_index_i),
    .wr_re_i  (value_real_i),
    .wr_im_i  (value_imag_i),
    .pt_re_o  (pt_re),
    .pt_im_o  (pt_im)
  );

  mdsd_dist #(
    .NumLanes    (NumLanes),
    .SampleWidth (SampleWidth)
  ) u_dist (
    .clk_i      (clk_i),
    .stage_en_i (stage_en[2:1]),
    .smp_re_i   (s1_re_q),
    .smp_im_i   (s1_im_q),
    .bps_i      (s1_bps_q),
    .pt_re_i    (pt_re),
    .pt_im_i    (pt_im),
    .lane_en_o  (lane_en),
    .dist_o     (lane_dist),
    .re_o       (lane_re),
    .im_o       (lane_im)
  );

  mdsd_min_tree #(
    .NumLanes    (NumLanes),
    .SampleWidth (SampleWidth)
  ) u_tree (
    .clk_i      (clk_i),
    .stage_en_i (stage_en[5:3]),
    .lane_en_i  (lane_en),
    .dist_i     (lane_dist),
    .re_i       (lane_re),
    .im_i       (lane_im),
    .best_idx_o (best_idx),
    .best_re_o  (nearest_real_o),
    .best_im_o  (nearest_imag_o)
  );

  // last tree stage is the output register
  assign out_valid_o     = vld_q[NStg-1];
  assign end_of_symbol_o = last_q[NStg-1];
  assign symbol_index_o  = mdsd_pkg::PointIdxW'(best_idx);

  // a load word never enters the pipe
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    tbl_we |=> !vld_q[0])
    else $error("load word entered the pipeline");

  // the table is never written while a demap word waits at the input stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !stage_en[0] |-> !tbl_we)
    else $error("table written under a stalled input stage");

  // the chosen index lies inside the searched part of the table
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      ((32'(symbol_index_o) >> mdsd_pkg::clamp_bps(bps_q)) == 32'd0))
    else $error("nearest index outside the constellation");

  // a word leaving the last tree input stage shows up at the output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[NStg-2] && stage_en[NStg-1]) |=> out_valid_o)
    else $error("word lost before the output register");

endmodule

`default_nettype wire

>>> dv/tb.sv
// self-checking testbench for the minimum distance symbol demapper core
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SW          = mdsd_pkg::SampleWidthDefault;
  localparam int TableDepth  = mdsd_pkg::MaxPointsDefault;
  localparam int IdxW        = mdsd_pkg::PointIdxW;
  localparam int CfgW        = mdsd_pkg::BpsW;
  // pipe depth plus margin, waited out before a config write and at the end
  localparam int DrainCycles = mdsd_pkg::NumStages + 6;
  // the limit lies far above the slowest legal run, so this is only a hang guard
  localparam int CycleLimit  = 400000;
  localparam int PhaseWords  = 198;
  // half pitch of the initial table grid: 0.25 in Q3.12
  localparam int GridStep    = 1024;

  // tracks the point table and the size register, and keeps the queue of
  // decisions that the demap words seen so far must produce, in order
  class demap_scoreboard;
    typedef struct packed {
      logic [IdxW-1:0]      index;
      logic signed [SW-1:0] re;
      logic signed [SW-1:0] im;
      logic                 eos;
    } decision_t;

    logic signed [SW-1:0] point_re [TableDepth];
    logic signed [SW-1:0] point_im [TableDepth];
    logic [CfgW-1:0]      bps;
    decision_t            expected_decisions[$];
    int                   mismatches;

    function new();
      bps        = mdsd_pkg::BpsReset;
      mismatches = 0;
    endfunction

    // number of table entries one demap word is compared against
    function int searched_points();
      int b;
      b = bps;
      if (b < 1) b = 1;
      if (b > 6) b = 6;
      return 1 << b;
    endfunction

    // an accepted input word: loads update the table, demaps queue a decision
    function void take_word(mdsd_pkg::action_e act, logic [IdxW-1:0] idx,
                            logic signed [SW-1:0] re, logic signed [SW-1:0] im,
                            logic last);
      decision_t d;
      longint    dr, di, sq_dist, best;
      int        n;
      if (act == mdsd_pkg::ActLoad) begin
        point_re[idx] = re;
        point_im[idx] = im;
        return;
      end
      best = 0;
      d.index = '0;
      // squared distance needs 33 bits, strict less-than keeps the lowest index
      for (n = 0; n < searched_points(); n++) begin
        dr      = longint'(re) - longint'(point_re[n]);
        di      = longint'(im) - longint'(point_im[n]);
        sq_dist = dr * dr + di * di;
        if (n == 0 || sq_dist < best) begin
          best    = sq_dist;
          d.index = IdxW'(n);
        end
      end
      d.re  = point_re[d.index];
      d.im  = point_im[d.index];
      d.eos = last;
      expected_decisions = {expected_decisions, d};
    endfunction

    function void flag_field(string field, longint want, longint got);
      if (want != got) begin
        mismatches++;
        $error("%s: expected %0d, got %0d", field, want, got);
      end
    endfunction

    // an accepted output word, compared with the oldest pending decision
    function void check_word(logic [IdxW-1:0] idx, logic signed [SW-1:0] re,
                             logic signed [SW-1:0] im, logic eos);
      decision_t d;
      if (expected_decisions.size() == 0) begin
        mismatches++;
        $error("output word with symbol_index %0d and nothing pending", idx);
        return;
      end
      d = expected_decisions.pop_front();
      flag_field("symbol_index", longint'(d.index), longint'(idx));
      flag_field("nearest_real", longint'(d.re), longint'(re));
      flag_field("nearest_imag", longint'(d.im), longint'(im));
      flag_field("end_of_symbol", longint'(d.eos), longint'(eos));
    endfunction
  endclass

  // all block inputs start from known values
  logic                 clk_i             = 1'b0;
  logic                 rst_ni            = 1'b0;
  logic                 in_valid_i        = 1'b0;
  logic                 action_i          = 1'b0;
  logic [IdxW-1:0]      point_index_i     = '0;
  logic signed [SW-1:0] value_real_i      = '0;
  logic signed [SW-1:0] value_imag_i      = '0;
  logic                 last_subcarrier_i = 1'b0;
  logic                 out_stall_i       = 1'b0;
  logic                 cfg_valid_i       = 1'b0;
  logic [CfgW-1:0]      cfg_data_i        = '0;

  logic                 in_stall_o;
  logic                 out_valid_o;
  logic [IdxW-1:0]      symbol_index_o;
  logic signed [SW-1:0] nearest_real_o;
  logic signed [SW-1:0] nearest_imag_o;
  logic                 end_of_symbol_o;
  logic                 cfg_ready_o;

  demap_scoreboard sb = new();

  // idle odds of both sides in percent, and the receiver's long hold-off
  int send_idle_pct = 37;
  int recv_idle_pct = 86;
  int hold_cycles   = 0;
  int cycle_count   = 0;

  min_distance_symbol_demapper_core u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .action_i          (action_i),
    .point_index_i     (point_index_i),
    .value_real_i      (value_real_i),
    .value_imag_i      (value_imag_i),
    .last_subcarrier_i (last_subcarrier_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .symbol_index_o    (symbol_index_o),
    .nearest_real_o    (nearest_real_o),
    .nearest_imag_o    (nearest_imag_o),
    .end_of_symbol_o   (end_of_symbol_o),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_data_i        (cfg_data_i)
  );

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // hang guard
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // output side: check the accepted word, then pick the next stall value.
  // a pending hold-off keeps the stall up and is counted down here
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_word(symbol_index_o, nearest_real_o, nearest_imag_o, end_of_symbol_o);
    end
    if (hold_cycles > 0) begin
      hold_cycles--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // clip to the Q3.12 range
  function automatic logic signed [SW-1:0] sat16(int v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return -16'sd32768;
    return v[SW-1:0];
  endfunction

  // offer one word after a random gap, hold it until accepted
  task automatic send_word(mdsd_pkg::action_e act, logic [IdxW-1:0] idx, int re, int im,
                           logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i        <= 1'b1;
    action_i          <= act;
    point_index_i     <= idx;
    value_real_i      <= sat16(re);
    value_imag_i      <= sat16(im);
    last_subcarrier_i <= last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.take_word(act, idx, sat16(re), sat16(im), last);
  endtask

  // size register write, only once the pipe has emptied; trailing loads give
  // no output word, so the drain wait covers them
  task automatic write_bps(logic [CfgW-1:0] v);
    in_valid_i <= 1'b0;
    while (sb.expected_decisions.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    sb.bps = v;
  endtask

  // one random word: mostly demaps near or between live points, some wild
  // samples and extremes, and occasional table rewrites (copies give ties)
  task automatic random_word();
    int count, a, b, kind, re, im;
    logic [IdxW-1:0] idx;
    count = sb.searched_points();
    a     = $urandom_range(count - 1);
    b     = $urandom_range(count - 1);
    kind  = $urandom_range(99);
    if (kind < 12) begin
      idx = $urandom_range(1) ? IdxW'($urandom_range(TableDepth - 1))
                              : IdxW'($urandom_range(count - 1));
      case ($urandom_range(3))
        0: begin
          re = int'($urandom_range(65535)) - 32768;
          im = int'($urandom_range(65535)) - 32768;
        end
        1: begin
          re = sb.point_re[b];
          im = sb.point_im[b];
        end
        default: begin
          re = (int'($urandom_range(15)) - 8) * 2048 + int'($urandom_range(63)) - 32;
          im = (int'($urandom_range(15)) - 8) * 2048 + int'($urandom_range(63)) - 32;
        end
      endcase
      send_word(mdsd_pkg::ActLoad, idx, re, im, 1'($urandom_range(1)));
    end else begin
      if (kind < 55) begin
        // noisy copy of a live point
        re = int'(sb.point_re[a]) + int'($urandom_range(1200)) - 600;
        im = int'(sb.point_im[a]) + int'($urandom_range(1200)) - 600;
      end else if (kind < 75) begin
        re = int'($urandom_range(65535)) - 32768;
        im = int'($urandom_range(65535)) - 32768;
      end else if (kind < 87) begin
        // halfway between two live points, often an exact tie
        re = (int'(sb.point_re[a]) + int'(sb.point_re[b])) >>> 1;
        im = (int'(sb.point_im[a]) + int'(sb.point_im[b])) >>> 1;
      end else begin
        case ($urandom_range(3))
          0: re = -32768;
          1: re = 32767;
          2: re = 0;
          default: re = -1;
        endcase
        case ($urandom_range(3))
          0: im = -32768;
          1: im = 32767;
          2: im = 0;
          default: im = -1;
        endcase
      end
      send_word(mdsd_pkg::ActDemap, IdxW'($urandom_range(TableDepth - 1)), re, im,
                ($urandom_range(7) == 0));
    end
  endtask

  // size settings of the random phases, out of range codes included
  logic [CfgW-1:0] bps_plan [9] = '{3'd6, 3'd1, 3'd0, 3'd7, 3'd3, 3'd4, 3'd5, 3'd2, 3'd6};

  initial begin
    int n, phase;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // write every entry first so no demap ever reads an unwritten point:
    // an 8 by 8 grid, 0.5 apart
    for (n = 0; n < TableDepth; n++) begin
      send_word(mdsd_pkg::ActLoad, IdxW'(n), (2 * (n % 8) - 7) * GridStep,
                (2 * (n / 8) - 7) * GridStep, 1'b0);
    end

    // directed words at the reset size of four points
    // extreme point, flag ignored
    send_word(mdsd_pkg::ActLoad, IdxW'(3), -32768, 32767, 1'b1);
    // duplicate of entry 1
    send_word(mdsd_pkg::ActLoad, IdxW'(2), -5 * GridStep, -7 * GridStep, 1'b0);
    send_word(mdsd_pkg::ActDemap, IdxW'(0), -32768, -32768, 1'b0);
    send_word(mdsd_pkg::ActDemap, IdxW'(63), 32767, 32767, 1'b1);
    // exactly on the extreme point
    send_word(mdsd_pkg::ActDemap, IdxW'(5), -32768, 32767, 1'b1);
    send_word(mdsd_pkg::ActDemap, IdxW'(42), 32767, -32768, 1'b0);
    send_word(mdsd_pkg::ActDemap, IdxW'(21), 0, 0, 1'b0);
    // duplicates tie, lowest index must win
    send_word(mdsd_pkg::ActDemap, IdxW'(0), -5 * GridStep, -7 * GridStep, 1'b1);
    // halfway between entries 0 and 1 (and 2): equal distances
    send_word(mdsd_pkg::ActDemap, IdxW'(0), -6 * GridStep, -7 * GridStep, 1'b0);
    send_word(mdsd_pkg::ActLoad, IdxW'(63), 32767, -32768, 1'b1);
    send_word(mdsd_pkg::ActLoad, IdxW'(0), 0, 0, 1'b0);
    send_word(mdsd_pkg::ActDemap, IdxW'(17), 1, -1, 1'b1);
    send_word(mdsd_pkg::ActDemap, IdxW'(0), -6 * GridStep, -7 * GridStep, 1'b0);

    // random phases: sender lightly and receiver heavily idle, then the
    // reverse, then both at full rate with one long receiver hold-off
    for (phase = 0; phase < 9; phase++) begin
      if (phase == 3) begin
        send_idle_pct = 86;
        recv_idle_pct = 37;
      end else if (phase == 6) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_bps(bps_plan[phase]);
      if (phase == 6) hold_cycles = 300;
      repeat (PhaseWords) random_word();
    end

    in_valid_i <= 1'b0;
    while (sb.expected_decisions.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> min_distance_symbol_demapper_core.f
rtl/mdsd_pkg.sv
rtl/mdsd_point_table.sv
rtl/mdsd_dist.sv
rtl/mdsd_min_tree.sv
rtl/min_distance_symbol_demapper_core.sv
dv/tb.sv
